// ===== sv/tlvg_pkg.sv =====
// ----------------------------------------------------------------------------
// tlvg_pkg
// Shared types and constants for the traffic latency vote governor.
// ----------------------------------------------------------------------------
package tlvg_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned ADDR_W = 5;
    localparam int unsigned APB_W  = 32;

    typedef enum logic [1:0] {
        MODE_WAITING = 2'd0,
        MODE_IDLE    = 2'd1,
        MODE_ACTIVE  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REG_BUSY_THRESHOLD  = 3'd0,
        REG_QUIET_THRESHOLD = 3'd1,
        REG_ACTIVE_PERIOD   = 3'd2,
        REG_IDLE_PERIOD     = 3'd3,
        REG_ACTIVE_LATENCY  = 3'd4
    } reg_idx_t;

    localparam logic [DATA_W-1:0] RST_BUSY_THRESHOLD  = 16'd100;
    localparam logic [DATA_W-1:0] RST_QUIET_THRESHOLD = 16'd10;
    localparam logic [DATA_W-1:0] RST_ACTIVE_PERIOD   = 16'd50;
    localparam logic [DATA_W-1:0] RST_IDLE_PERIOD     = 16'd1000;
    localparam logic [DATA_W-1:0] RST_ACTIVE_LATENCY  = 16'd7;

    localparam logic [DATA_W-1:0] COUNT_MAX = {DATA_W{1'b1}};

    typedef struct packed {
        logic [DATA_W-1:0] busy_threshold;
        logic [DATA_W-1:0] quiet_threshold;
        logic [DATA_W-1:0] active_period_ticks;
        logic [DATA_W-1:0] idle_period_ticks;
        logic [DATA_W-1:0] active_latency;
    } cfg_t;

    typedef struct packed {
        mode_t             governor_mode;
        logic              request_held;
        logic [DATA_W-1:0] requested_latency;
        logic              request_changed;
    } result_t;

endpackage

// ===== sv/tlvg_regs.sv =====
// ----------------------------------------------------------------------------
// tlvg_regs
// APB register file holding the thresholds, window lengths and latency value.
// ----------------------------------------------------------------------------
module tlvg_regs
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlvg_pkg::ADDR_W-1:0]   paddr,
    input  logic [tlvg_pkg::APB_W-1:0]    pwdata,
    output logic [tlvg_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    output tlvg_pkg::cfg_t                cfg
);

    tlvg_pkg::cfg_t             cfg_reg;
    tlvg_pkg::cfg_t             cfg_next;
    logic                       wr_en;
    logic [2:0]                 idx;
    logic [tlvg_pkg::DATA_W-1:0] wdata;
    logic [tlvg_pkg::DATA_W-1:0] rdata;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = paddr[tlvg_pkg::ADDR_W-1:2];
    assign wdata  = pwdata[tlvg_pkg::DATA_W-1:0];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                tlvg_pkg::REG_BUSY_THRESHOLD:  cfg_next.busy_threshold      = wdata;
                tlvg_pkg::REG_QUIET_THRESHOLD: cfg_next.quiet_threshold     = wdata;
                tlvg_pkg::REG_ACTIVE_PERIOD:   cfg_next.active_period_ticks = wdata;
                tlvg_pkg::REG_IDLE_PERIOD:     cfg_next.idle_period_ticks   = wdata;
                tlvg_pkg::REG_ACTIVE_LATENCY:  cfg_next.active_latency      = wdata;
                default:                       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            tlvg_pkg::REG_BUSY_THRESHOLD:  rdata = cfg_reg.busy_threshold;
            tlvg_pkg::REG_QUIET_THRESHOLD: rdata = cfg_reg.quiet_threshold;
            tlvg_pkg::REG_ACTIVE_PERIOD:   rdata = cfg_reg.active_period_ticks;
            tlvg_pkg::REG_IDLE_PERIOD:     rdata = cfg_reg.idle_period_ticks;
            tlvg_pkg::REG_ACTIVE_LATENCY:  rdata = cfg_reg.active_latency;
            default:                       rdata = '0;
        endcase
    end

    assign prdata = {{(tlvg_pkg::APB_W-tlvg_pkg::DATA_W){1'b0}}, rdata};
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.busy_threshold      <= tlvg_pkg::RST_BUSY_THRESHOLD;
            cfg_reg.quiet_threshold     <= tlvg_pkg::RST_QUIET_THRESHOLD;
            cfg_reg.active_period_ticks <= tlvg_pkg::RST_ACTIVE_PERIOD;
            cfg_reg.idle_period_ticks   <= tlvg_pkg::RST_IDLE_PERIOD;
            cfg_reg.active_latency      <= tlvg_pkg::RST_ACTIVE_LATENCY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/tlvg_core.sv =====
// ----------------------------------------------------------------------------
// tlvg_core
// Mode, packet count and window countdown, updated once per accepted item.
// ----------------------------------------------------------------------------
module tlvg_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              command,
    input  logic              vote,
    input  tlvg_pkg::cfg_t    cfg,
    output tlvg_pkg::result_t result
);

    tlvg_pkg::mode_t             mode_reg;
    tlvg_pkg::mode_t             mode_next;
    logic [tlvg_pkg::DATA_W-1:0] count_reg;
    logic [tlvg_pkg::DATA_W-1:0] count_next;
    logic [tlvg_pkg::DATA_W-1:0] countdown_reg;
    logic [tlvg_pkg::DATA_W-1:0] countdown_next;
    logic                        armed_reg;
    logic                        armed_next;
    logic                        changed;
    logic                        held;

    always_comb
    begin
        mode_next      = mode_reg;
        count_next     = count_reg;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        changed        = 1'b0;

        if (!command)
        begin
            if (vote)
            begin
                if (count_reg != tlvg_pkg::COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
                if (mode_reg == tlvg_pkg::MODE_WAITING)
                begin
                    mode_next      = tlvg_pkg::MODE_IDLE;
                    countdown_next = cfg.idle_period_ticks;
                    armed_next     = 1'b1;
                end
            end
        end
        else if (armed_reg)
        begin
            // A countdown of zero or one expires on this tick.
            if (countdown_reg <= 16'd1)
            begin
                armed_next     = 1'b0;
                countdown_next = '0;
                count_next     = '0;
                case (mode_reg)
                    tlvg_pkg::MODE_IDLE:
                    begin
                        if (count_reg < cfg.busy_threshold)
                        begin
                            mode_next = tlvg_pkg::MODE_WAITING;
                        end
                        else
                        begin
                            mode_next      = tlvg_pkg::MODE_ACTIVE;
                            changed        = 1'b1;
                            countdown_next = cfg.active_period_ticks;
                            armed_next     = 1'b1;
                        end
                    end
                    tlvg_pkg::MODE_ACTIVE:
                    begin
                        if (count_reg < cfg.quiet_threshold)
                        begin
                            mode_next      = tlvg_pkg::MODE_IDLE;
                            changed        = 1'b1;
                            countdown_next = cfg.idle_period_ticks;
                        end
                        else
                        begin
                            countdown_next = cfg.active_period_ticks;
                        end
                        armed_next = 1'b1;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            else
            begin
                countdown_next = countdown_reg - 1'b1;
            end
        end
    end

    assign held = (mode_next == tlvg_pkg::MODE_ACTIVE);

    always_comb
    begin
        result.governor_mode     = mode_next;
        result.request_held      = held;
        result.requested_latency = held ? cfg.active_latency : '0;
        result.request_changed   = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= tlvg_pkg::MODE_WAITING;
            count_reg     <= '0;
            countdown_reg <= '0;
            armed_reg     <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
        end
    end

endmodule

// ===== sv/tlvg_skid.sv =====
// ----------------------------------------------------------------------------
// tlvg_skid
// Result register with a skid stage, so input ready never waits on out stall.
// ----------------------------------------------------------------------------
module tlvg_skid
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  tlvg_pkg::result_t push_data,
    output logic              full,
    output logic              out_valid,
    input  logic              out_stall,
    output tlvg_pkg::result_t out_data
);

    tlvg_pkg::result_t main_reg;
    tlvg_pkg::result_t skid_reg;
    logic              main_valid_reg;
    logic              skid_valid_reg;
    logic              main_free;

    assign main_free = !main_valid_reg || !out_stall;
    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // No item is pushed while the skid stage is full.
    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

// ===== sv/traffic_latency_vote_governor.sv =====
// ----------------------------------------------------------------------------
// traffic_latency_vote_governor
// Low-latency request governor driven by transfer votes and millisecond ticks.
//
//   Channel   Handshake             Payload
//   input     in_valid / in_stall   command, vote
//   output    out_valid / out_stall governor_mode, request_held,
//                                   requested_latency, request_changed
//   config    APB (psel, penable)   paddr, pwdata, prdata
//
// One item per cycle while in_stall is low; the governor state updates in
// the cycle the item is accepted and its result is registered for output.
// A two-entry result buffer raises in_stall only when both entries are full.
// Reset is asynchronous; registers return to their documented defaults.
// ----------------------------------------------------------------------------
module traffic_latency_vote_governor
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic                          vote,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    governor_mode,
    output logic                          request_held,
    output logic [tlvg_pkg::DATA_W-1:0]   requested_latency,
    output logic                          request_changed,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tlvg_pkg::ADDR_W-1:0]   paddr,
    input  logic [tlvg_pkg::APB_W-1:0]    pwdata,
    output logic [tlvg_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);

    tlvg_pkg::cfg_t    cfg;
    tlvg_pkg::result_t core_result;
    tlvg_pkg::result_t out_data;
    logic              accept;
    logic              full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    tlvg_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tlvg_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .command (command),
        .vote    (vote),
        .cfg     (cfg),
        .result  (core_result)
    );

    tlvg_skid u_skid
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign governor_mode     = out_data.governor_mode;
    assign request_held      = out_data.request_held;
    assign requested_latency = out_data.requested_latency;
    assign request_changed   = out_data.request_changed;

endmodule

// ===== sv/tlvg_checker.sv =====
// ----------------------------------------------------------------------------
// tlvg_checker
// Port-level checks on the governor's result channel.
// ----------------------------------------------------------------------------
module tlvg_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [1:0]                  governor_mode,
    input logic                        request_held,
    input logic [tlvg_pkg::DATA_W-1:0] requested_latency,
    input logic                        request_changed
);

    // A stalled result keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(governor_mode)
            && $stable(request_held) && $stable(requested_latency)
            && $stable(request_changed))
        else $error("stalled result changed");

    // The request is held exactly while the governor is active.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> request_held == (governor_mode == tlvg_pkg::MODE_ACTIVE))
        else $error("request_held disagrees with mode");

    // A released request reports a latency of zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !request_held |-> requested_latency == '0)
        else $error("latency shown while request released");

    // A change of request implies the mode went to or came from active.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && request_changed |->
            governor_mode == tlvg_pkg::MODE_ACTIVE || governor_mode == tlvg_pkg::MODE_IDLE)
        else $error("request change in waiting mode");

endmodule

bind traffic_latency_vote_governor tlvg_checker u_tlvg_checker
(
    .clk               (clk),
    .rst_n             (rst_n),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .governor_mode     (governor_mode),
    .request_held      (request_held),
    .requested_latency (requested_latency),
    .request_changed   (request_changed)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the traffic latency vote governor. A directed table
// covers reset behavior, every window transition and the ignored fields, then
// a short vote burst under the top busy threshold shows that an idle window
// falls back to waiting. Random phases follow, most with small windows and
// thresholds, each under its own register set. Every result is compared field
// by field to its pinned row or a behavioral governor run on each accepted item.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic CMD_VOTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Register slots past the end of the map; writes there must be dropped.
    localparam int unsigned NUM_REGS  = 5;
    localparam int unsigned LAST_SLOT = (1 << (tlvg_pkg::ADDR_W - 2)) - 1;

    localparam int unsigned BURST_VOTES     = 16;
    localparam int unsigned RAND_PHASES     = 7;
    localparam int unsigned ITEMS_PER_PHASE = 100;
    localparam int unsigned PRESSURE_PHASE  = 3;
    localparam int unsigned HOLD_CYCLES     = 120;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned WATCHDOG_LIMIT  = 1000;
    localparam int unsigned IDLE_PCT        = 8;

    typedef struct packed {
        logic              cmd;
        logic              vote;
        logic              pinned;
        tlvg_pkg::result_t want;
    } stim_row_t;

    localparam tlvg_pkg::result_t NO_PIN       = '0;
    localparam tlvg_pkg::result_t AT_WAITING   = '{tlvg_pkg::MODE_WAITING, 1'b0, 16'h0000, 1'b0};
    localparam tlvg_pkg::result_t AT_IDLE      = '{tlvg_pkg::MODE_IDLE,    1'b0, 16'h0000, 1'b0};
    localparam tlvg_pkg::result_t IDLE_RELEASE = '{tlvg_pkg::MODE_IDLE,    1'b0, 16'h0000, 1'b1};
    localparam tlvg_pkg::result_t ACTIVE_ENTER = '{tlvg_pkg::MODE_ACTIVE,  1'b1, 16'hFFFF, 1'b1};
    localparam tlvg_pkg::result_t ACTIVE_HELD  = '{tlvg_pkg::MODE_ACTIVE,  1'b1, 16'hFFFF, 1'b0};

    // Items sent straight after reset, before any register is written.
    localparam stim_row_t RESET_ROWS [3] = '{
        '{CMD_TICK, 1'b0, 1'b1, AT_WAITING},
        '{CMD_TICK, 1'b1, 1'b1, AT_WAITING},
        '{CMD_VOTE, 1'b0, 1'b1, AT_WAITING}
    };

    // Run with busy 2, quiet 2, active period 0, idle period 2, latency all ones.
    localparam stim_row_t DIRECTED [20] = '{
        '{CMD_VOTE, 1'b1, 1'b1, AT_IDLE},
        '{CMD_TICK, 1'b0, 1'b1, AT_IDLE},
        '{CMD_VOTE, 1'b1, 1'b1, AT_IDLE},
        '{CMD_TICK, 1'b0, 1'b1, ACTIVE_ENTER},
        '{CMD_VOTE, 1'b1, 1'b1, ACTIVE_HELD},
        '{CMD_TICK, 1'b0, 1'b1, IDLE_RELEASE},
        '{CMD_TICK, 1'b0, 1'b1, AT_IDLE},
        '{CMD_TICK, 1'b1, 1'b1, AT_WAITING},
        '{CMD_VOTE, 1'b0, 1'b1, AT_WAITING},
        '{CMD_VOTE, 1'b1, 1'b1, AT_IDLE},
        '{CMD_VOTE, 1'b1, 1'b0, NO_PIN},
        '{CMD_VOTE, 1'b1, 1'b0, NO_PIN},
        '{CMD_TICK, 1'b0, 1'b1, AT_IDLE},
        '{CMD_TICK, 1'b0, 1'b1, ACTIVE_ENTER},
        '{CMD_VOTE, 1'b1, 1'b0, NO_PIN},
        '{CMD_VOTE, 1'b1, 1'b0, NO_PIN},
        '{CMD_TICK, 1'b0, 1'b1, ACTIVE_HELD},
        '{CMD_TICK, 1'b0, 1'b1, IDLE_RELEASE},
        '{CMD_TICK, 1'b1, 1'b1, AT_IDLE},
        '{CMD_TICK, 1'b1, 1'b1, AT_WAITING}
    };

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          command;
    logic                          vote;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    governor_mode;
    logic                          request_held;
    logic [tlvg_pkg::DATA_W-1:0]   requested_latency;
    logic                          request_changed;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [tlvg_pkg::ADDR_W-1:0]   paddr;
    logic [tlvg_pkg::APB_W-1:0]    pwdata;
    logic [tlvg_pkg::APB_W-1:0]    prdata;
    logic                          pready;

    // Typed expectation travelling with the item currently offered.
    logic                          pin_valid;
    tlvg_pkg::result_t             pin_result;

    // Behavioral copy of the governor.
    tlvg_pkg::cfg_t                gov_cfg;
    tlvg_pkg::mode_t               gov_mode;
    logic [tlvg_pkg::DATA_W-1:0]   pkt_count;
    logic [tlvg_pkg::DATA_W-1:0]   window_left;
    logic                          window_armed;

    tlvg_pkg::result_t             pending_results [$];
    int unsigned                   mismatches;
    bit                            steady;
    bit                            hold_pending;

    traffic_latency_vote_governor dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .command           (command),
        .vote              (vote),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .governor_mode     (governor_mode),
        .request_held      (request_held),
        .requested_latency (requested_latency),
        .request_changed   (request_changed),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic tlvg_pkg::result_t govern_step(input logic cmd, input logic v);
        tlvg_pkg::result_t r;
        logic              changed;
        changed = 1'b0;
        if (cmd == CMD_VOTE)
        begin
            if (v)
            begin
                if (pkt_count != tlvg_pkg::COUNT_MAX)
                    pkt_count = pkt_count + 1'b1;
                if (gov_mode == tlvg_pkg::MODE_WAITING)
                begin
                    gov_mode     = tlvg_pkg::MODE_IDLE;
                    window_left  = gov_cfg.idle_period_ticks;
                    window_armed = 1'b1;
                end
            end
        end
        else if (window_armed)
        begin
            if (window_left <= 1)
            begin
                // The window expires: decide the next mode, then clear the count.
                window_armed = 1'b0;
                window_left  = '0;
                case (gov_mode)
                    tlvg_pkg::MODE_IDLE:
                    begin
                        if (pkt_count < gov_cfg.busy_threshold)
                            gov_mode = tlvg_pkg::MODE_WAITING;
                        else
                        begin
                            gov_mode     = tlvg_pkg::MODE_ACTIVE;
                            changed      = 1'b1;
                            window_left  = gov_cfg.active_period_ticks;
                            window_armed = 1'b1;
                        end
                    end
                    tlvg_pkg::MODE_ACTIVE:
                    begin
                        if (pkt_count < gov_cfg.quiet_threshold)
                        begin
                            gov_mode     = tlvg_pkg::MODE_IDLE;
                            changed      = 1'b1;
                            window_left  = gov_cfg.idle_period_ticks;
                        end
                        else
                            window_left  = gov_cfg.active_period_ticks;
                        window_armed = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
                pkt_count = '0;
            end
            else
                window_left = window_left - 1'b1;
        end
        r.governor_mode     = gov_mode;
        r.request_held      = (gov_mode == tlvg_pkg::MODE_ACTIVE);
        r.requested_latency = (gov_mode == tlvg_pkg::MODE_ACTIVE) ?
                              gov_cfg.active_latency : '0;
        r.request_changed   = changed;
        return r;
    endfunction

    // Predicts each accepted item and checks each accepted result.
    always @(posedge clk)
    begin : scoreboard
        tlvg_pkg::result_t want;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                want = govern_step(command, vote);
                if (pin_valid)
                    want = pin_result;
                pending_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    $error("result arrived with no item outstanding");
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (governor_mode !== want.governor_mode)
                    begin
                        mismatches++;
                        $error("governor_mode: expected %0d, got %0d",
                               want.governor_mode, governor_mode);
                    end
                    if (request_held !== want.request_held)
                    begin
                        mismatches++;
                        $error("request_held: expected %0d, got %0d",
                               want.request_held, request_held);
                    end
                    if (requested_latency !== want.requested_latency)
                    begin
                        mismatches++;
                        $error("requested_latency: expected %0d, got %0d",
                               want.requested_latency, requested_latency);
                    end
                    if (request_changed !== want.request_changed)
                    begin
                        mismatches++;
                        $error("request_changed: expected %0d, got %0d",
                               want.request_changed, request_changed);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, none while steady, and one long hold-off on request.
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int unsigned dead_cycles;
        dead_cycles = 0;
        while (dead_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                dead_cycles = 0;
            else
                dead_cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic send_item(input stim_row_t row);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        command    <= row.cmd;
        vote       <= row.vote;
        pin_valid  <= row.pinned;
        pin_result <= row.want;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Stop offering items and wait until every result is back.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input int unsigned idx,
                             input logic [tlvg_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= tlvg_pkg::ADDR_W'(idx << 2);
        pwdata  <= tlvg_pkg::APB_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            tlvg_pkg::REG_BUSY_THRESHOLD:  gov_cfg.busy_threshold      = value;
            tlvg_pkg::REG_QUIET_THRESHOLD: gov_cfg.quiet_threshold     = value;
            tlvg_pkg::REG_ACTIVE_PERIOD:   gov_cfg.active_period_ticks = value;
            tlvg_pkg::REG_IDLE_PERIOD:     gov_cfg.idle_period_ticks   = value;
            tlvg_pkg::REG_ACTIVE_LATENCY:  gov_cfg.active_latency      = value;
            default:
            begin
            end
        endcase
        @(posedge clk);
    endtask

    task automatic set_config(input logic [tlvg_pkg::DATA_W-1:0] busy,
                              input logic [tlvg_pkg::DATA_W-1:0] quiet,
                              input logic [tlvg_pkg::DATA_W-1:0] act,
                              input logic [tlvg_pkg::DATA_W-1:0] idl,
                              input logic [tlvg_pkg::DATA_W-1:0] lat);
        write_reg(tlvg_pkg::REG_BUSY_THRESHOLD, busy);
        write_reg(tlvg_pkg::REG_QUIET_THRESHOLD, quiet);
        write_reg(tlvg_pkg::REG_ACTIVE_PERIOD, act);
        write_reg(tlvg_pkg::REG_IDLE_PERIOD, idl);
        write_reg(tlvg_pkg::REG_ACTIVE_LATENCY, lat);
    endtask

    initial
    begin : stimulus
        logic [tlvg_pkg::DATA_W-1:0] busy;
        logic [tlvg_pkg::DATA_W-1:0] quiet;
        logic [tlvg_pkg::DATA_W-1:0] act;
        logic [tlvg_pkg::DATA_W-1:0] idl;
        logic [tlvg_pkg::DATA_W-1:0] lat;
        int unsigned                 tick_pct;
        int unsigned                 counted;
        stim_row_t                   row;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        command      = CMD_VOTE;
        vote         = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        pin_valid    = 1'b0;
        pin_result   = NO_PIN;
        steady       = 1'b0;
        hold_pending = 1'b0;
        mismatches   = 0;

        gov_cfg.busy_threshold      = tlvg_pkg::RST_BUSY_THRESHOLD;
        gov_cfg.quiet_threshold     = tlvg_pkg::RST_QUIET_THRESHOLD;
        gov_cfg.active_period_ticks = tlvg_pkg::RST_ACTIVE_PERIOD;
        gov_cfg.idle_period_ticks   = tlvg_pkg::RST_IDLE_PERIOD;
        gov_cfg.active_latency      = tlvg_pkg::RST_ACTIVE_LATENCY;
        gov_mode     = tlvg_pkg::MODE_WAITING;
        pkt_count    = '0;
        window_left  = '0;
        window_armed = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (RESET_ROWS[i])
            send_item(RESET_ROWS[i]);
        settle();

        set_config(16'd2, 16'd2, 16'd0, 16'd2, 16'hFFFF);
        foreach (DIRECTED[i])
            send_item(DIRECTED[i]);
        settle();

        // Under the top busy threshold a vote burst never reaches active, so
        // each idle window closes back to waiting.
        set_config(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd0);
        repeat (2)
        begin
            for (int unsigned n = 0; n < BURST_VOTES; n++)
                send_item('{CMD_VOTE, 1'b1, 1'b0, NO_PIN});
            send_item('{CMD_TICK, 1'b0, 1'b0, NO_PIN});
        end
        repeat (2) send_item('{CMD_TICK, 1'b1, 1'b0, NO_PIN});
        settle();

        for (int unsigned ph = 0; ph < RAND_PHASES; ph++)
        begin
            busy = tlvg_pkg::DATA_W'($urandom_range(6));
            quiet = tlvg_pkg::DATA_W'($urandom_range(6));
            act = tlvg_pkg::DATA_W'($urandom_range(5));
            idl = tlvg_pkg::DATA_W'($urandom_range(5));
            lat = tlvg_pkg::DATA_W'($urandom);
            case (ph)
                0:
                begin
                    busy  = '0;
                    quiet = '0;
                    lat   = '0;
                end
                1:
                begin
                    act = '1;
                    lat = '1;
                end
                2:
                begin
                    idl   = '1;
                    quiet = '1;
                end
                4:
                begin
                    write_reg(NUM_REGS, 16'hFFFF);
                    write_reg(LAST_SLOT, 16'hFFFF);
                end
                default:
                begin
                end
            endcase
            set_config(busy, quiet, act, idl, lat);
            tick_pct = $urandom_range(20, 60);
            steady = (ph == PRESSURE_PHASE);
            hold_pending = (ph == PRESSURE_PHASE);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                row.cmd    = ($urandom_range(99) < tick_pct) ? CMD_TICK : CMD_VOTE;
                row.vote   = ($urandom_range(99) < 85);
                row.pinned = 1'b0;
                row.want   = NO_PIN;
                send_item(row);
                // Votes of zero leave the governor untouched.
                if (row.cmd == CMD_TICK || row.vote)
                    counted++;
            end
            settle();
            steady = 1'b0;
        end

        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
